>>> sv/gso_pkg.sv
// ----------------------------------------------------------------------------
// Orthonormalizer package
// Shared widths, register indexes and the request bundle of the multiplier.
// ----------------------------------------------------------------------------
package gso_pkg;

  localparam int unsigned MAX_DIMS = 8;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned ADDR_W   = 2 * IDX_W;
  localparam int unsigned CFG_W    = 4;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned RAW_W    = 32;
  localparam int unsigned WRK_W    = 48;
  localparam int unsigned INV_W    = 38;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_DIMS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_AXES = 1'b1;

  typedef struct packed {
    logic               start;
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic [6:0]         shift;
  } mul_req_t;

endpackage

>>> sv/gso_if.sv
// ----------------------------------------------------------------------------
// Orthonormalizer channels
// Valid/ready channels for raw components in and unit components out.
// ----------------------------------------------------------------------------
interface gso_in_if;
  logic                            valid;
  logic                            ready;
  logic [gso_pkg::IDX_W-1:0]       axis_index;
  logic [gso_pkg::IDX_W-1:0]       dim_index;
  logic signed [gso_pkg::RAW_W-1:0] component;

  modport source (output valid, axis_index, dim_index, component, input ready);
  modport sink   (input valid, axis_index, dim_index, component, output ready);
endinterface

interface gso_out_if;
  logic                       valid;
  logic                       ready;
  logic [gso_pkg::IDX_W-1:0]  out_axis;
  logic [gso_pkg::IDX_W-1:0]  out_dim;
  logic signed [31:0]         unit_component;
  logic                       degenerate;
  logic                       last;

  modport source (output valid, out_axis, out_dim, unit_component, degenerate, last,
                  input ready);
  modport sink   (input valid, out_axis, out_dim, unit_component, degenerate, last,
                  output ready);
endinterface

>>> sv/gso_mul.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed (a*b)>>s, truncated toward zero and saturated to 64 bits, built from
// four 32x32 partial products accumulated one after another.
// ----------------------------------------------------------------------------
module gso_mul (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  gso_pkg::mul_req_t      req_i,
  output logic                   done_o,
  output logic signed [63:0]     res_o
);
  import gso_pkg::*;

  logic [63:0]  ua_q, ub_q;
  logic         neg_q;
  logic [6:0]   s_q;
  logic [127:0] acc_q;
  logic [2:0]   cnt_q;
  logic         busy_q;
  logic         done_q;
  logic signed [63:0] res_q;

  logic [31:0]  opa, opb;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [127:0] sh_w;
  logic [63:0]  mag;
  logic [63:0]  res_w;

  always_comb begin
    opa = cnt_q[1] ? ua_q[63:32] : ua_q[31:0];
    opb = cnt_q[0] ? ub_q[63:32] : ub_q[31:0];
    pp  = opa * opb;
    case (cnt_q[1:0])
      2'd0:    pp_sh = {64'b0, pp};
      2'd3:    pp_sh = {pp, 64'b0};
      default: pp_sh = {32'b0, pp, 32'b0};
    endcase
    sh_w = acc_q >> s_q;
    if (neg_q) begin
      mag = ((|sh_w[127:64]) || (sh_w[63:0] > 64'h8000_0000_0000_0000)) ?
            64'h8000_0000_0000_0000 : sh_w[63:0];
      res_w = 64'd0 - mag;
    end else begin
      mag   = (|sh_w[127:63]) ? 64'h7FFF_FFFF_FFFF_FFFF : sh_w[63:0];
      res_w = mag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ua_q   <= '0;
      ub_q   <= '0;
      neg_q  <= 1'b0;
      s_q    <= '0;
      acc_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      res_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        ua_q   <= req_i.a[63] ? 64'd0 - req_i.a : req_i.a;
        ub_q   <= req_i.b[63] ? 64'd0 - req_i.b : req_i.b;
        neg_q  <= req_i.a[63] ^ req_i.b[63];
        s_q    <= req_i.shift;
        acc_q  <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (cnt_q == 3'd4) begin
          res_q  <= res_w;
          done_q <= 1'b1;
          busy_q <= 1'b0;
        end else begin
          acc_q <= acc_q + pp_sh;
          cnt_q <= cnt_q + 3'd1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> sv/gso_recip.sv
// ----------------------------------------------------------------------------
// Reciprocal unit
// Normalizes a positive self-dot one bit a cycle, then divides 2^62-1 by its
// top 32 bits one quotient bit a cycle. Result packs shift and mantissa.
// ----------------------------------------------------------------------------
module gso_recip (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [63:0]           self_i,
  output logic                         done_o,
  output logic [gso_pkg::INV_W-1:0]    res_o
);
  import gso_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_NORM = 2'd1;
  localparam logic [1:0] PH_DIV  = 2'd2;

  logic [1:0]  phase_q;
  logic [63:0] dn_q;
  logic [5:0]  sh_q;
  logic [31:0] rem_q;
  logic [31:0] quo_q;
  logic [5:0]  cnt_q;
  logic        done_q;
  logic [INV_W-1:0] res_q;

  logic [32:0] trial;
  logic        take;
  logic [31:0] quo_nx;

  always_comb begin
    trial  = {rem_q, 1'b1};
    take   = trial >= {1'b0, dn_q[63:32]};
    quo_nx = {quo_q[30:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      dn_q    <= '0;
      sh_q    <= '0;
      rem_q   <= '0;
      quo_q   <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (phase_q)
        PH_IDLE: begin
          if (start_i) begin
            if (self_i[63] || (self_i == 64'sd0)) begin
              res_q  <= '0;
              done_q <= 1'b1;
            end else begin
              dn_q    <= self_i;
              sh_q    <= '0;
              phase_q <= PH_NORM;
            end
          end
        end
        PH_NORM: begin
          if (dn_q[63]) begin
            rem_q   <= '0;
            quo_q   <= '0;
            cnt_q   <= '0;
            phase_q <= PH_DIV;
          end else begin
            dn_q <= {dn_q[62:0], 1'b0};
            sh_q <= sh_q + 6'd1;
          end
        end
        PH_DIV: begin
          rem_q <= take ? 32'(trial - {1'b0, dn_q[63:32]}) : trial[31:0];
          quo_q <= quo_nx;
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd61) begin
            res_q   <= {sh_q, quo_nx};
            done_q  <= 1'b1;
            phase_q <= PH_IDLE;
          end
        end
        default: phase_q <= PH_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> sv/gso_isqrt.sv
// ----------------------------------------------------------------------------
// Integer square root
// Digit-by-digit square root of a 64-bit value, one result bit a cycle.
// ----------------------------------------------------------------------------
module gso_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] x_i,
  output logic        done_o,
  output logic [31:0] res_o
);
  import gso_pkg::*;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_ALIGN = 2'd1;
  localparam logic [1:0] PH_RUN   = 2'd2;

  logic [1:0]  phase_q;
  logic [63:0] x_q, r_q, bit_q;
  logic        done_q;
  logic [31:0] res_q;
  logic [64:0] sum;

  assign sum = {1'b0, r_q} + {1'b0, bit_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      x_q     <= '0;
      r_q     <= '0;
      bit_q   <= '0;
      done_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (phase_q)
        PH_IDLE: begin
          if (start_i) begin
            x_q     <= x_i;
            r_q     <= '0;
            bit_q   <= 64'h4000_0000_0000_0000;
            phase_q <= PH_ALIGN;
          end
        end
        PH_ALIGN: begin
          if (bit_q > x_q) bit_q <= bit_q >> 2;
          else phase_q <= PH_RUN;
        end
        PH_RUN: begin
          if (bit_q == 64'd0) begin
            res_q   <= r_q[31:0];
            done_q  <= 1'b1;
            phase_q <= PH_IDLE;
          end else begin
            if ({1'b0, x_q} >= sum) begin
              x_q <= 64'({1'b0, x_q} - sum);
              r_q <= (r_q >> 1) + bit_q;
            end else begin
              r_q <= r_q >> 1;
            end
            bit_q <= bit_q >> 2;
          end
        end
        default: phase_q <= PH_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> sv/gram_schmidt_orthonormalizer_unit.sv
// ----------------------------------------------------------------------------
// Gram-Schmidt orthonormalizer
// Loads raw vectors, orthonormalizes them by modified Gram-Schmidt and streams
// out the unit components, axis-major, with the final one marked.
//
// Usage: raw Q16.16 components arrive on in_i, one per transfer, tagged with
// axis and dimension. Items outside the configured size are dropped. Each
// stored item counts; the transfer that completes num_axes*num_dims items, as
// clamped, starts the pass. While loading, in_i takes one transfer a cycle.
// The pass copies the raw set into the working memory (a read and a write per
// entry), cuts each axis against every earlier non-degenerate axis (a dot
// product, a coefficient, then an update per component), takes each
// self-dot's reciprocal with one-bit normalize and divide loops and each
// non-degenerate axis's square root, then emits each Q2.30 component.
// All products go through one shared 32x32 multiplier in four steps.
// in_i is not ready during the pass; a stalled out_o holds the pass at the
// next result. After reset the sizes are 3 and 3 and the load count is zero;
// a configuration write clears the load count.
// ----------------------------------------------------------------------------
module gram_schmidt_orthonormalizer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gso_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [gso_pkg::CFG_W-1:0]     cfg_data_i,
  gso_in_if.sink                        in_i,
  gso_out_if.source                     out_o
);
  import gso_pkg::*;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_CP_RD   = 5'd1;
  localparam logic [4:0] S_CP_WR   = 5'd2;
  localparam logic [4:0] S_AX      = 5'd3;
  localparam logic [4:0] S_DT_RD   = 5'd4;
  localparam logic [4:0] S_DT_MUL  = 5'd5;
  localparam logic [4:0] S_DT_WAIT = 5'd6;
  localparam logic [4:0] S_RC      = 5'd7;
  localparam logic [4:0] S_RC_WAIT = 5'd8;
  localparam logic [4:0] S_CF      = 5'd9;
  localparam logic [4:0] S_CF_WAIT = 5'd10;
  localparam logic [4:0] S_UP_RD   = 5'd11;
  localparam logic [4:0] S_UP_MUL  = 5'd12;
  localparam logic [4:0] S_UP_WAIT = 5'd13;
  localparam logic [4:0] S_EM_ROW  = 5'd14;
  localparam logic [4:0] S_SQ_WAIT = 5'd15;
  localparam logic [4:0] S_EM_RD   = 5'd16;
  localparam logic [4:0] S_EM_MUL  = 5'd17;
  localparam logic [4:0] S_EM_WAIT = 5'd18;
  localparam logic [4:0] S_EM_OUT  = 5'd19;

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) sat_add64 = s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    else sat_add64 = s[63:0];
  endfunction

  function automatic logic [63:0] sext48(input logic [WRK_W-1:0] v);
    sext48 = {{16{v[WRK_W-1]}}, v};
  endfunction

  // Memories and their ports.
  logic [RAW_W-1:0] raw_mem [MAX_DIMS*MAX_DIMS];
  logic [WRK_W-1:0] w_mem   [MAX_DIMS*MAX_DIMS];
  logic [INV_W-1:0] inv_mem [MAX_DIMS];
  logic [RAW_W-1:0] raw_rd_q;
  logic [WRK_W-1:0] wa_rd_q, wb_rd_q;

  logic              raw_we, raw_re, w_we, w_re, inv_we;
  logic [ADDR_W-1:0] raw_waddr, w_addr_a, w_addr_b;
  logic [WRK_W-1:0]  w_wdata;
  logic [IDX_W-1:0]  inv_idx;
  logic [INV_W-1:0]  inv_rd;

  // Control state.
  logic [4:0]       state_q;
  logic [6:0]       count_q;
  logic [CFG_W-1:0] num_dims_q, num_axes_q;
  logic [IDX_W-1:0] i_q, j_q, d_q;
  logic signed [63:0] acc_q, c_q;
  logic [31:0]      s_val_q;
  logic [4:0]       h_q;
  logic             deg_q;
  logic [31:0]      unit_q;

  logic             ovalid_q;
  logic [IDX_W-1:0] oaxis_q, odim_q;
  logic [31:0]      ounit_q;
  logic             odeg_q, olast_q;

  // Sizes in use.
  logic [CFG_W-1:0] n_eff, m_eff;
  logic [7:0]       mn;
  logic [7:0]       count_nx;
  logic             in_fire, in_ok, d_last, i_last;
  logic             out_load;

  // Shared units.
  mul_req_t           mul_req;
  logic               mul_done, rc_done, sq_done;
  logic signed [63:0] mul_res;
  logic [INV_W-1:0]   rc_res;
  logic [31:0]        sq_res;
  logic [63:0]        sq_x;
  logic [65:0]        diff;
  logic [WRK_W-1:0]   upd_val;
  logic [31:0]        unit_sat;

  always_comb begin
    if (num_dims_q == '0) n_eff = CFG_W'(1);
    else if (num_dims_q > CFG_W'(MAX_DIMS)) n_eff = CFG_W'(MAX_DIMS);
    else n_eff = num_dims_q;
    if (num_axes_q == '0) m_eff = CFG_W'(1);
    else if (num_axes_q > n_eff) m_eff = n_eff;
    else m_eff = num_axes_q;
    mn       = {4'b0, m_eff} * {4'b0, n_eff};
    count_nx = {1'b0, count_q} + 8'd1;
  end

  assign in_fire = in_i.valid && in_i.ready;
  assign in_ok   = ({1'b0, in_i.axis_index} < m_eff) && ({1'b0, in_i.dim_index} < n_eff);
  assign d_last  = ({1'b0, d_q} == n_eff - CFG_W'(1));
  assign i_last  = ({1'b0, i_q} == m_eff - CFG_W'(1));
  assign in_i.ready = (state_q == S_IDLE);
  assign out_load = (state_q == S_EM_OUT) && (!ovalid_q || out_o.ready);

  // Cut update and output clamp.
  always_comb begin
    diff = {{18{wa_rd_q[WRK_W-1]}}, wa_rd_q} - {{2{mul_res[63]}}, mul_res};
    if (diff[65:47] != {19{diff[65]}})
      upd_val = diff[65] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
    else
      upd_val = diff[47:0];
    if (mul_res[63:31] != {33{mul_res[63]}})
      unit_sat = mul_res[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else
      unit_sat = mul_res[31:0];
  end

  // Memory port control.
  always_comb begin
    raw_we    = in_fire && in_ok;
    raw_waddr = {in_i.axis_index, in_i.dim_index};
    raw_re    = (state_q == S_CP_RD);
    w_we      = (state_q == S_CP_WR) || ((state_q == S_UP_WAIT) && mul_done);
    w_wdata   = (state_q == S_CP_WR) ? {{16{raw_rd_q[RAW_W-1]}}, raw_rd_q} : upd_val;
    w_re      = (state_q == S_DT_RD) || (state_q == S_UP_RD) || (state_q == S_EM_RD);
    w_addr_a  = {i_q, d_q};
    w_addr_b  = {j_q, d_q};
    inv_we    = (state_q == S_RC_WAIT) && rc_done;
    inv_idx   = (state_q == S_EM_ROW) ? i_q : j_q;
    inv_rd    = inv_mem[inv_idx];
    sq_x      = inv_rd[32] ? {inv_rd[30:0], 33'b0} : {inv_rd[31:0], 32'b0};
  end

  always_ff @(posedge clk_i) begin
    if (raw_we) raw_mem[raw_waddr] <= in_i.component;
    if (raw_re) raw_rd_q <= raw_mem[{i_q, d_q}];
    if (w_we) w_mem[w_addr_a] <= w_wdata;
    if (w_re) begin
      wa_rd_q <= w_mem[w_addr_a];
      wb_rd_q <= w_mem[w_addr_b];
    end
    if (inv_we) inv_mem[i_q] <= rc_res;
  end

  // Multiplier requests.
  always_comb begin
    mul_req = '0;
    unique case (state_q)
      S_DT_MUL: begin
        mul_req.start = 1'b1;
        mul_req.a     = sext48(wa_rd_q);
        mul_req.b     = sext48(wb_rd_q);
        mul_req.shift = 7'd16;
      end
      S_CF: begin
        mul_req.start = 1'b1;
        mul_req.a     = acc_q;
        mul_req.b     = {32'b0, inv_rd[31:0]};
        mul_req.shift = 7'd78 - {1'b0, inv_rd[37:32]};
      end
      S_UP_MUL: begin
        mul_req.start = 1'b1;
        mul_req.a     = c_q;
        mul_req.b     = sext48(wb_rd_q);
        mul_req.shift = 7'd16;
      end
      S_EM_MUL: begin
        mul_req.start = !deg_q;
        mul_req.a     = sext48(wa_rd_q);
        mul_req.b     = {32'b0, s_val_q};
        mul_req.shift = 7'd41 - {2'b0, h_q};
      end
      default: mul_req = '0;
    endcase
  end

  gso_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  gso_recip u_recip (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_RC),
    .self_i  (acc_q),
    .done_o  (rc_done),
    .res_o   (rc_res)
  );

  gso_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i ((state_q == S_EM_ROW) && (inv_rd != '0)),
    .x_i     (sq_x),
    .done_o  (sq_done),
    .res_o   (sq_res)
  );

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      num_dims_q <= CFG_W'(3);
      num_axes_q <= CFG_W'(3);
      i_q        <= '0;
      j_q        <= '0;
      d_q        <= '0;
      acc_q      <= '0;
      c_q        <= '0;
      s_val_q    <= '0;
      h_q        <= '0;
      deg_q      <= 1'b0;
      unit_q     <= '0;
      ovalid_q   <= 1'b0;
      oaxis_q    <= '0;
      odim_q     <= '0;
      ounit_q    <= '0;
      odeg_q     <= 1'b0;
      olast_q    <= 1'b0;
    end else begin
      if (out_load) ovalid_q <= 1'b1;
      else if (out_o.ready) ovalid_q <= 1'b0;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_NUM_DIMS: num_dims_q <= cfg_data_i;
          CFG_NUM_AXES: num_axes_q <= cfg_data_i;
          default: ;
        endcase
        count_q <= '0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_fire && in_ok) begin
            if (count_nx == mn) begin
              count_q <= '0;
              i_q     <= '0;
              d_q     <= '0;
              state_q <= S_CP_RD;
            end else begin
              count_q <= count_nx[6:0];
            end
          end
        end
        S_CP_RD: state_q <= S_CP_WR;
        S_CP_WR: begin
          if (d_last) begin
            d_q <= '0;
            if (i_last) begin
              i_q     <= '0;
              j_q     <= '0;
              state_q <= S_AX;
            end else begin
              i_q     <= i_q + IDX_W'(1);
              state_q <= S_CP_RD;
            end
          end else begin
            d_q     <= d_q + IDX_W'(1);
            state_q <= S_CP_RD;
          end
        end
        S_AX: begin
          // Degenerate earlier axes leave this one unchanged and are skipped.
          if ((j_q != i_q) && (inv_rd == '0)) begin
            j_q <= j_q + IDX_W'(1);
          end else begin
            acc_q   <= '0;
            d_q     <= '0;
            state_q <= S_DT_RD;
          end
        end
        S_DT_RD:  state_q <= S_DT_MUL;
        S_DT_MUL: state_q <= S_DT_WAIT;
        S_DT_WAIT: begin
          if (mul_done) begin
            acc_q <= sat_add64(acc_q, mul_res);
            if (d_last) begin
              d_q     <= '0;
              state_q <= (j_q == i_q) ? S_RC : S_CF;
            end else begin
              d_q     <= d_q + IDX_W'(1);
              state_q <= S_DT_RD;
            end
          end
        end
        S_RC: state_q <= S_RC_WAIT;
        S_RC_WAIT: begin
          if (rc_done) begin
            j_q <= '0;
            if (i_last) begin
              i_q     <= '0;
              state_q <= S_EM_ROW;
            end else begin
              i_q     <= i_q + IDX_W'(1);
              state_q <= S_AX;
            end
          end
        end
        S_CF: state_q <= S_CF_WAIT;
        S_CF_WAIT: begin
          if (mul_done) begin
            c_q     <= mul_res;
            d_q     <= '0;
            state_q <= S_UP_RD;
          end
        end
        S_UP_RD:  state_q <= S_UP_MUL;
        S_UP_MUL: state_q <= S_UP_WAIT;
        S_UP_WAIT: begin
          if (mul_done) begin
            if (d_last) begin
              d_q     <= '0;
              j_q     <= j_q + IDX_W'(1);
              state_q <= S_AX;
            end else begin
              d_q     <= d_q + IDX_W'(1);
              state_q <= S_UP_RD;
            end
          end
        end
        S_EM_ROW: begin
          deg_q   <= (inv_rd == '0);
          h_q     <= inv_rd[37:33];
          d_q     <= '0;
          state_q <= (inv_rd == '0) ? S_EM_RD : S_SQ_WAIT;
        end
        S_SQ_WAIT: begin
          if (sq_done) begin
            s_val_q <= sq_res;
            state_q <= S_EM_RD;
          end
        end
        S_EM_RD: state_q <= S_EM_MUL;
        S_EM_MUL: begin
          if (deg_q) begin
            unit_q  <= '0;
            state_q <= S_EM_OUT;
          end else begin
            state_q <= S_EM_WAIT;
          end
        end
        S_EM_WAIT: begin
          if (mul_done) begin
            unit_q  <= unit_sat;
            state_q <= S_EM_OUT;
          end
        end
        S_EM_OUT: begin
          if (out_load) begin
            oaxis_q  <= i_q;
            odim_q   <= d_q;
            ounit_q  <= unit_q;
            odeg_q   <= deg_q;
            olast_q  <= i_last && d_last;
            if (d_last) begin
              d_q <= '0;
              if (i_last) begin
                state_q <= S_IDLE;
              end else begin
                i_q     <= i_q + IDX_W'(1);
                state_q <= S_EM_ROW;
              end
            end else begin
              d_q     <= d_q + IDX_W'(1);
              state_q <= S_EM_RD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid          = ovalid_q;
  assign out_o.out_axis       = oaxis_q;
  assign out_o.out_dim        = odim_q;
  assign out_o.unit_component = ounit_q;
  assign out_o.degenerate     = odeg_q;
  assign out_o.last           = olast_q;

endmodule

>>> tb/sv/tb_gram_schmidt_orthonormalizer_unit.sv
// ----------------------------------------------------------------------------
// Gram-Schmidt orthonormalizer testbench
// Loads sets of raw Q16.16 vectors through the input channel, predicts the
// Q2.30 unit components with a fixed-point model of the modified Gram-Schmidt
// pass, and compares every output transfer in order, field by field.
// ----------------------------------------------------------------------------
module tb_gram_schmidt_orthonormalizer_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import gso_pkg::*;

  typedef struct packed {
    logic [2:0]         ax;
    logic [2:0]         dm;
    logic signed [31:0] unit;
    logic               degen;
    logic               last;
  } unit_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_NUM_DIMS;
  logic [CFG_W-1:0] cfg_data_i = '0;

  gso_in_if  in_ch ();
  gso_out_if out_ch ();

  gram_schmidt_orthonormalizer_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_i(in_ch.sink), .out_o(out_ch.source)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state.
  logic signed [63:0] raw_store [64];
  logic [63:0] inv_dot [8];
  int unsigned set_count;
  int unsigned dims_reg, axes_reg;
  unit_res_t expected_units [$];
  int errors;
  int hold_cycles;
  bit random_stall;

  function automatic int unsigned n_dims();
    if (dims_reg < 1) return 1;
    return dims_reg > MAX_DIMS ? MAX_DIMS : dims_reg;
  endfunction

  function automatic int unsigned n_axes();
    if (axes_reg < 1) return 1;
    return axes_reg > n_dims() ? n_dims() : axes_reg;
  endfunction

  function automatic logic signed [63:0] sat_add(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_sub(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) - 65'(b);
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] clamp48(logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
    if (v < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
    return v;
  endfunction

  // Full-width product shifted right, truncated toward zero, saturated to 64 bits.
  function automatic logic signed [63:0] prod_shift(logic signed [63:0] a,
                                                    logic signed [63:0] b, int unsigned s);
    logic neg;
    logic [127:0] p;
    logic [63:0] ua, ub, lim;
    neg = (a < 0) != (b < 0);
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    p = {64'd0, ua} * {64'd0, ub};
    p = s >= 128 ? '0 : p >> s;
    lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    if (p[127:64] != 0 || p[63:0] > lim) p[63:0] = lim;
    return neg ? -p[63:0] : p[63:0];
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r, bt;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > x) bt >>= 2;
    while (bt != 0) begin
      if (x >= r + bt) begin
        x -= r + bt;
        r = (r >> 1) + bt;
      end else begin
        r >>= 1;
      end
      bt >>= 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] pack_recip(logic signed [63:0] self_dot);
    logic [63:0] dn;
    int unsigned sh;
    if (self_dot <= 0) return 0;
    dn = self_dot;
    sh = 0;
    while (!dn[63]) begin
      dn <<= 1;
      sh++;
    end
    return (((64'd1 << 62) - 1) / dn[63:32]) | (64'(sh) << 32);
  endfunction

  function automatic logic signed [63:0] dot_q16(const ref logic signed [63:0] w [64],
                                                 int unsigned ia, int unsigned ib);
    logic signed [63:0] acc;
    acc = 0;
    for (int d = 0; d < n_dims(); d++)
      acc = sat_add(acc, prod_shift(w[ia*8+d], w[ib*8+d], 16));
    return acc;
  endfunction

  task automatic orthonormalize_set();
    logic signed [63:0] w [64];
    logic signed [63:0] c, s;
    logic [63:0] inv;
    int unsigned sh, m, n;
    unit_res_t r;
    m = n_axes();
    n = n_dims();
    w = raw_store;
    for (int i = 0; i < m; i++) begin
      for (int j = 0; j < i; j++) begin
        sh = 32'(inv_dot[j][37:32]);
        c = prod_shift(dot_q16(w, i, j), {32'd0, inv_dot[j][31:0]}, 78 - sh);
        for (int d = 0; d < n; d++)
          w[i*8+d] = clamp48(sat_sub(w[i*8+d], prod_shift(c, w[j*8+d], 16)));
      end
      inv_dot[i] = pack_recip(dot_q16(w, i, i));
    end
    for (int i = 0; i < m; i++) begin
      inv = inv_dot[i];
      sh = 32'(inv[37:32]);
      s = int_sqrt({32'd0, inv[31:0]} << (32 + (sh & 1)));
      for (int d = 0; d < n; d++) begin
        c = 0;
        if (inv != 0) begin
          c = prod_shift(w[i*8+d], s, 41 - sh / 2);
          if (c > 64'sh7FFF_FFFF) c = 64'sh7FFF_FFFF;
          if (c < -64'sh8000_0000) c = -64'sh8000_0000;
        end
        r.ax = 3'(i);
        r.dm = 3'(d);
        r.unit = c[31:0];
        r.degen = inv == 0;
        r.last = (i == m - 1) && (d == n - 1);
        expected_units.push_back(r);
      end
    end
  endtask

  function automatic int rand_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(0, 2);
  endfunction

  // Leaves valid high after the transfer so that the next item can follow at
  // once; release_input drops it when the sender goes quiet.
  task automatic send_component(int unsigned ax, int unsigned dm, logic [31:0] val, bit gaps);
    int g;
    g = gaps ? rand_gap() : 0;
    @(negedge clk_i);
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.axis_index <= IDX_W'(ax);
    in_ch.dim_index <= IDX_W'(dm);
    in_ch.component <= val;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if (ax < n_axes() && dm < n_dims()) begin
      raw_store[ax*8+dm] = $signed(val);
      set_count = (set_count + 1) & 7'h7F;
      if (set_count >= n_axes() * n_dims()) begin
        set_count = 0;
        orthonormalize_set();
      end
    end
  endtask

  task automatic release_input();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    release_input();
    while (expected_units.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= CFG_W'(val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_NUM_DIMS) dims_reg = val;
    else axes_reg = val;
    set_count = 0;
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1: return 0;
      2: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
      3: return $signed($urandom_range(0, 2**20)) - 2**19;
      default: return $urandom();
    endcase
  endfunction

  // Loads every entry of the configured set once, in order, with content chosen by kind.
  task automatic load_set(bit gaps, int kind);
    for (int a = 0; a < n_axes(); a++)
      for (int d = 0; d < n_dims(); d++) begin
        case (kind)
          0: send_component(a, d, (a == d) ? 32'h0001_0000 : 32'h0, gaps);
          1: send_component(a, d, a == 0 ? 32'h0 : 32'h0002_0000, gaps);
          2: send_component(a, d, (a == 1) ? 32'h0003_0000 : 32'h0001_8000, gaps);
          default: send_component(a, d, rand_value(), gaps);
        endcase
      end
  endtask

  task automatic test_directed();
    load_set(0, 0);              // identity at reset sizes
    load_set(0, 2);              // second axis dependent on the first after cut
    send_component(7, 0, 32'h1234, 0);  // out of range, ignored
    send_component(0, 7, 32'h1234, 0);
    send_component(0, 0, 32'h7FFF_FFFF, 0);
    send_component(0, 0, 32'h8000_0000, 0);  // repeat index overwrites and counts
    send_component(1, 1, 32'h0, 0);
    send_component(2, 2, 32'h0001_0000, 0);
    for (int k = 0; k < 5; k++) send_component(k % 3, 2 - k % 3, 32'hFFFF_0000, 0);
  endtask

  task automatic test_sizes();
    write_reg(CFG_NUM_DIMS, 1);
    write_reg(CFG_NUM_AXES, 1);
    load_set(0, 0);
    load_set(0, 3);
    write_reg(CFG_NUM_DIMS, 8);
    write_reg(CFG_NUM_AXES, 8);
    load_set(0, 0);
    load_set(1, 1);              // zero-length first axis
    write_reg(CFG_NUM_DIMS, 0);  // clamped to one
    write_reg(CFG_NUM_AXES, 15);
    load_set(1, 3);
    write_reg(CFG_NUM_DIMS, 15);
    write_reg(CFG_NUM_AXES, 0);
    load_set(1, 3);
  endtask

  task automatic test_random();
    int sent;
    sent = 0;
    while (sent < 160) begin
      write_reg(CFG_NUM_DIMS, $urandom_range(1, 4));
      write_reg(CFG_NUM_AXES, $urandom_range(1, 4));
      for (int k = 0; k < 4; k++) begin
        if ($urandom_range(0, 4) == 0) begin
          send_component($urandom_range(0, 7), $urandom_range(0, 7), rand_value(), 1);
          sent++;
        end
        load_set(1, 3);
        sent += n_axes() * n_dims();
      end
    end
  endtask

  task automatic test_backpressure();
    write_reg(CFG_NUM_DIMS, 2);
    write_reg(CFG_NUM_AXES, 2);
    hold_cycles = 3000;
    repeat (3) load_set(0, 3);
  endtask

  // Receiver: random stalls, plus a long hold-off when requested.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles--;
      end else if (random_stall) begin
        out_ch.ready <= $urandom_range(0, 3) != 0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_units.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        unit_res_t e;
        e = expected_units.pop_front();
        if (out_ch.out_axis !== e.ax) begin
          $error("out_axis exp %0d got %0d", e.ax, out_ch.out_axis); errors++;
        end
        if (out_ch.out_dim !== e.dm) begin
          $error("out_dim exp %0d got %0d", e.dm, out_ch.out_dim); errors++;
        end
        if (out_ch.unit_component !== e.unit) begin
          $error("unit_component exp %h got %h", e.unit, out_ch.unit_component); errors++;
        end
        if (out_ch.degenerate !== e.degen) begin
          $error("degenerate exp %0b got %0b", e.degen, out_ch.degenerate); errors++;
        end
        if (out_ch.last !== e.last) begin
          $error("last exp %0b got %0b", e.last, out_ch.last); errors++;
        end
      end
    end
  end

  initial begin
    #50ms;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.axis_index = '0;
    in_ch.dim_index = '0;
    in_ch.component = '0;
    errors = 0;
    hold_cycles = 0;
    random_stall = 0;
    dims_reg = 3;
    axes_reg = 3;
    set_count = 0;
    for (int k = 0; k < 64; k++) raw_store[k] = 0;
    for (int k = 0; k < 8; k++) inv_dot[k] = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_sizes();
    test_backpressure();
    random_stall = 1;
    test_random();
    drain();
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
